@@ rtl/cdms_pkg.sv @@
// package for the closest display mode search unit
// holds sizes, opcodes, sequencer types and the shared distance limit
// no dependencies
`default_nettype none

package cdms_pkg;

    // default table capacity
    localparam int unsigned MAX_MODES_DEF = 32;

    // one table entry: width, height, depth
    localparam int unsigned W_W     = 16;
    localparam int unsigned H_W     = 16;
    localparam int unsigned D_W     = 8;
    localparam int unsigned ENTRY_W = W_W + H_W + D_W;
    localparam int unsigned INDEX_W = 5;

    // distances fit in 16 bits, so a 17-bit all-ones value beats none
    localparam int unsigned DIST_W = 16;
    localparam logic [DIST_W:0] FAR_AWAY = '1;

    // opcodes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // table passes of a search
    typedef enum logic [1:0] {
        PASS_HEIGHT,
        PASS_WIDTH,
        PASS_DEPTH
    } pass_t;

endpackage

`default_nettype wire

@@ rtl/cdms_ram.sv @@
// generic single write, single read port ram with registered read data
// no dependencies
`default_nettype none

module cdms_ram #(
    parameter int unsigned WIDTH = 40,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/closest_display_mode_search_unit.sv @@
// top level of the closest display mode search unit
// depends on cdms_pkg and cdms_ram
//
// Usage: a command is transferred at a rising edge with start high and busy
// low. opcode load appends (width, height, depth) to the mode table; loads
// once the table holds MAX_MODES entries are dropped. clear empties the
// table. search returns one result; opcode 3 does nothing. Load and clear
// never raise busy.
// A search over n stored modes walks the table three times through the one
// ram read port and one shared distance/compare unit: each walk issues n
// reads, takes in the registered ram read data and then closes, and done
// pulses once the depth walk has closed. busy is high for the walks and
// low again in the cycle done is shown, so a new command may be taken there.
// A search on an empty table pulses done in the cycle after the transfer
// with no_modes high and all other result fields zero; busy stays low.
// Result ports hold valid data only while done is high, for one cycle;
// the receiver cannot stall.
// Reset empties the table and returns the sequencer to idle; table contents
// are left as they are and never read before being written again.
`default_nettype none

module closest_display_mode_search_unit #(
    parameter int unsigned MAX_MODES = cdms_pkg::MAX_MODES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [1:0]   opcode,
    input  wire logic [15:0]  width,
    input  wire logic [15:0]  height,
    input  wire logic [7:0]   depth,
    output logic              done,
    output logic              no_modes,
    output logic [4:0]        found_index,
    output logic [15:0]       found_width,
    output logic [15:0]       found_height,
    output logic [7:0]        found_depth
);

    localparam int unsigned IDX_W   = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
    localparam int unsigned COUNT_W = $clog2(MAX_MODES + 1);
    localparam int unsigned EXT_W   = (IDX_W > cdms_pkg::INDEX_W) ? IDX_W
                                                                   : cdms_pkg::INDEX_W;
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_MODES);

    // control state
    cdms_pkg::state_t state_reg, state_next;
    cdms_pkg::pass_t  pass_reg, pass_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               done_reg, done_next;

    // datapath registers
    logic [IDX_W-1:0]            rd_idx_reg, rd_idx_next;
    logic [cdms_pkg::W_W-1:0]    tgt_w_reg, tgt_w_next;
    logic [cdms_pkg::H_W-1:0]    tgt_h_reg, tgt_h_next;
    logic [cdms_pkg::D_W-1:0]    tgt_d_reg, tgt_d_next;
    logic [cdms_pkg::DIST_W:0]   best_reg, best_next;
    logic [IDX_W-1:0]            sel_idx_reg, sel_idx_next;
    logic [cdms_pkg::W_W-1:0]    sel_w_reg, sel_w_next;
    logic [cdms_pkg::H_W-1:0]    sel_h_reg, sel_h_next;
    logic [cdms_pkg::D_W-1:0]    sel_d_reg, sel_d_next;
    logic                        no_modes_reg, no_modes_next;
    logic [cdms_pkg::INDEX_W-1:0] found_index_reg, found_index_next;
    logic [cdms_pkg::W_W-1:0]    found_width_reg, found_width_next;
    logic [cdms_pkg::H_W-1:0]    found_height_reg, found_height_next;
    logic [cdms_pkg::D_W-1:0]    found_depth_reg, found_depth_next;

    // handshake decode
    logic accept, acc_load, acc_clear, acc_search, pass_end;
    logic [cdms_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic ram_we;

    assign busy       = (state_reg == cdms_pkg::ST_SCAN);
    assign accept     = start && !busy;
    assign acc_load   = accept && (opcode == cdms_pkg::OP_LOAD);
    assign acc_clear  = accept && (opcode == cdms_pkg::OP_CLEAR);
    assign acc_search = accept && (opcode == cdms_pkg::OP_SEARCH);
    assign pass_end   = (state_reg == cdms_pkg::ST_SCAN) && (rd_cnt_reg == count_reg)
                        && !rd_vld_reg;

    assign ram_we    = acc_load && (count_reg < COUNT_MAX);
    assign ram_wdata = {width, height, depth};

    // mode table
    cdms_ram #(
        .WIDTH (cdms_pkg::ENTRY_W),
        .DEPTH (MAX_MODES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // fields of the entry read last cycle
    logic [cdms_pkg::W_W-1:0] e_w;
    logic [cdms_pkg::H_W-1:0] e_h;
    logic [cdms_pkg::D_W-1:0] e_d;
    assign e_w = ram_rdata[cdms_pkg::ENTRY_W-1 -: cdms_pkg::W_W];
    assign e_h = ram_rdata[cdms_pkg::D_W + cdms_pkg::H_W - 1 -: cdms_pkg::H_W];
    assign e_d = ram_rdata[cdms_pkg::D_W-1:0];

    // shared distance and compare unit; operands picked by pass
    // within the width and depth walks the current pick always carries the
    // kept height (and width), so the pick registers serve as the keys
    logic [cdms_pkg::DIST_W-1:0] op_a, op_b, diff;
    logic                        match, better;

    always_comb
    begin
        op_a  = '0;
        op_b  = '0;
        match = 1'b0;
        case (pass_reg)
            cdms_pkg::PASS_HEIGHT:
            begin
                op_a  = e_h;
                op_b  = tgt_h_reg;
                match = 1'b1;
            end
            cdms_pkg::PASS_WIDTH:
            begin
                op_a  = e_w;
                op_b  = tgt_w_reg;
                match = (e_h == sel_h_reg);
            end
            cdms_pkg::PASS_DEPTH:
            begin
                op_a  = cdms_pkg::DIST_W'(e_d);
                op_b  = cdms_pkg::DIST_W'(tgt_d_reg);
                match = (e_h == sel_h_reg) && (e_w == sel_w_reg);
            end
            default:
            begin
                match = 1'b0;
            end
        endcase
        diff   = (op_a >= op_b) ? (op_a - op_b) : (op_b - op_a);
        better = rd_vld_reg && match && ({1'b0, diff} < best_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdms_pkg::ST_IDLE:
            begin
                if (acc_search && (count_reg != '0))
                begin
                    state_next = cdms_pkg::ST_SCAN;
                end
            end
            cdms_pkg::ST_SCAN:
            begin
                if (pass_end && (pass_reg == cdms_pkg::PASS_DEPTH))
                begin
                    state_next = cdms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdms_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath next values
    logic [EXT_W-1:0] sel_ext;
    assign sel_ext = EXT_W'(sel_idx_reg);

    always_comb
    begin
        pass_next         = pass_reg;
        count_next        = count_reg;
        rd_cnt_next       = rd_cnt_reg;
        rd_vld_next       = 1'b0;
        rd_idx_next       = rd_cnt_reg[IDX_W-1:0];
        done_next         = 1'b0;
        tgt_w_next        = tgt_w_reg;
        tgt_h_next        = tgt_h_reg;
        tgt_d_next        = tgt_d_reg;
        best_next         = best_reg;
        sel_idx_next      = sel_idx_reg;
        sel_w_next        = sel_w_reg;
        sel_h_next        = sel_h_reg;
        sel_d_next        = sel_d_reg;
        no_modes_next     = no_modes_reg;
        found_index_next  = found_index_reg;
        found_width_next  = found_width_reg;
        found_height_next = found_height_reg;
        found_depth_next  = found_depth_reg;

        // table bookkeeping
        if (ram_we)
        begin
            count_next = count_reg + 1'b1;
        end
        if (acc_clear)
        begin
            count_next = '0;
        end

        // search start
        if (acc_search)
        begin
            tgt_w_next  = width;
            tgt_h_next  = height;
            tgt_d_next  = depth;
            pass_next   = cdms_pkg::PASS_HEIGHT;
            rd_cnt_next = '0;
            best_next   = cdms_pkg::FAR_AWAY;
            if (count_reg == '0)
            begin
                done_next         = 1'b1;
                no_modes_next     = 1'b1;
                found_index_next  = '0;
                found_width_next  = '0;
                found_height_next = '0;
                found_depth_next  = '0;
            end
        end

        // table walk
        if (state_reg == cdms_pkg::ST_SCAN)
        begin
            if (rd_cnt_reg < count_reg)
            begin
                rd_vld_next = 1'b1;
                rd_cnt_next = rd_cnt_reg + 1'b1;
            end
            if (better)
            begin
                best_next    = {1'b0, diff};
                sel_idx_next = rd_idx_reg;
                sel_w_next   = e_w;
                sel_h_next   = e_h;
                sel_d_next   = e_d;
            end
            if (pass_end)
            begin
                rd_cnt_next = '0;
                best_next   = cdms_pkg::FAR_AWAY;
                case (pass_reg)
                    cdms_pkg::PASS_HEIGHT: pass_next = cdms_pkg::PASS_WIDTH;
                    cdms_pkg::PASS_WIDTH:  pass_next = cdms_pkg::PASS_DEPTH;
                    default:
                    begin
                        pass_next         = cdms_pkg::PASS_HEIGHT;
                        done_next         = 1'b1;
                        no_modes_next     = 1'b0;
                        found_index_next  = sel_ext[cdms_pkg::INDEX_W-1:0];
                        found_width_next  = sel_w_reg;
                        found_height_next = sel_h_reg;
                        found_depth_next  = sel_d_reg;
                    end
                endcase
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cdms_pkg::ST_IDLE;
            pass_reg   <= cdms_pkg::PASS_HEIGHT;
            count_reg  <= '0;
            rd_cnt_reg <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pass_reg   <= pass_next;
            count_reg  <= count_next;
            rd_cnt_reg <= rd_cnt_next;
            rd_vld_reg <= rd_vld_next;
            done_reg   <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg       <= rd_idx_next;
        tgt_w_reg        <= tgt_w_next;
        tgt_h_reg        <= tgt_h_next;
        tgt_d_reg        <= tgt_d_next;
        best_reg         <= best_next;
        sel_idx_reg      <= sel_idx_next;
        sel_w_reg        <= sel_w_next;
        sel_h_reg        <= sel_h_next;
        sel_d_reg        <= sel_d_next;
        no_modes_reg     <= no_modes_next;
        found_index_reg  <= found_index_next;
        found_width_reg  <= found_width_next;
        found_height_reg <= found_height_next;
        found_depth_reg  <= found_depth_next;
    end

    assign done         = done_reg;
    assign no_modes     = no_modes_reg;
    assign found_index  = found_index_reg;
    assign found_width  = found_width_reg;
    assign found_height = found_height_reg;
    assign found_depth  = found_depth_reg;

    // checks

    // the fill count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("mode count beyond capacity");

    // the table does not change under a running search
    a_count_held: assert property (@(posedge clk) disable iff (!rst_n)
        busy && $past(busy) |-> $stable(count_reg))
        else $error("mode count changed during search");

    // every read handled by the walk lies inside the filled part
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (COUNT_W'(rd_idx_reg) < count_reg))
        else $error("walk read beyond filled entries");

    // an empty-table result carries only the flag
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && no_modes |-> (found_index == '0) && (found_width == '0)
                             && (found_height == '0) && (found_depth == '0))
        else $error("empty-table result not cleared");

    // a walk result follows the closing of the depth walk
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done && !no_modes |-> $past(pass_end) && ($past(pass_reg) == cdms_pkg::PASS_DEPTH))
        else $error("result without finished search");

endmodule

`default_nettype wire
